// ===== sv/sha256_hash_engine_defines.svh =====
// Assertion macros for the SHA-256 hash engine.
// Included by files that assert; no other dependencies.
`ifndef SHA256_HASH_ENGINE_DEFINES_SVH
`define SHA256_HASH_ENGINE_DEFINES_SVH
`ifndef SYNTHESIS
// Checked property, disabled while in reset
`define SHA_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Checked property, also active during reset
`define SHA_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define SHA_ASSERT(name, prop, msg)
`define SHA_ASSERT_ALWAYS(name, prop, msg)
`endif
`endif

// ===== sv/sha_pkg.sv =====
// Shared types, constants and round functions for the SHA-256 hash engine.
// No dependencies.
package sha_pkg;

  localparam int WORD_W   = 32;
  localparam int BLK_WORDS = 16;
  localparam int ROUNDS   = 64;

  // Input commands
  localparam logic CMD_ABSORB = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_ROUND,
    ST_FINAL,
    ST_OUT
  } state_e;

  // How the buffered block is formatted while it streams into the rounds
  typedef struct packed {
    logic [6:0] lim;     // bytes below this come from the buffer
    logic       mark;    // put 0x80 at byte lim
    logic       len;     // words 14 and 15 carry the bit length
    logic       second;  // a length-only block follows this one
  } blk_cfg_t;

  localparam logic [WORD_W-1:0] H_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [WORD_W-1:0] K_TAB [ROUNDS] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [WORD_W-1:0] rotr(input logic [WORD_W-1:0] x, input int n);
    return (x >> n) | (x << (WORD_W - n));
  endfunction

  function automatic logic [WORD_W-1:0] big_sigma0(input logic [WORD_W-1:0] x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [WORD_W-1:0] big_sigma1(input logic [WORD_W-1:0] x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [WORD_W-1:0] small_sigma0(input logic [WORD_W-1:0] x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [WORD_W-1:0] small_sigma1(input logic [WORD_W-1:0] x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [WORD_W-1:0] choose(input logic [WORD_W-1:0] e,
                                               input logic [WORD_W-1:0] f,
                                               input logic [WORD_W-1:0] g);
    return (e & f) ^ (~e & g);
  endfunction

  function automatic logic [WORD_W-1:0] majority(input logic [WORD_W-1:0] a,
                                                 input logic [WORD_W-1:0] b,
                                                 input logic [WORD_W-1:0] c);
    return (a & b) ^ (a & c) ^ (b & c);
  endfunction

endpackage

// ===== sv/sha_ifs.sv =====
// Valid/ready stream interfaces for the SHA-256 hash engine.
// Input: command plus message byte. Output: digest word, index, last flag.
interface sha_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] data_byte;

  modport source (output valid, command, data_byte, input ready);
  modport sink   (input valid, command, data_byte, output ready);
endinterface

interface sha_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

// ===== sv/sha256_hash_engine.sv =====
// SHA-256 hash engine over a byte stream.
// Input channel in_i: each transaction carries a command. Absorb appends
// data_byte to the 64-byte block buffer; finish pads the message, appends
// the 64-bit big-endian bit length and emits the digest.
// Output channel out_o: eight transactions per finish, digest words 0..7,
// last_word set on word 7.
// Bytes are absorbed back to back until the block is full. The 64th byte of a
// block starts a compression: a load step, 64 rounds at one round per cycle,
// and a step to fold the result into the hash, with in_i.ready low
// throughout. Sustained absorb rate is set by the single round unit.
// Finish runs one compression, or two when more than 55 bytes are pending,
// then presents the words one per cycle while out_o.ready is high; a stall
// holds the current word. in_i.ready stays low until word 7 is taken; the
// engine then starts a new message with the initial hash.
// The block buffer is a 16 x 32 synchronous RAM (one write, one read port,
// read data registered); padding is applied as words are read, so the RAM
// needs no clearing. Reset is asynchronous and puts the engine in the empty
// message state, ready for input at once.
`include "sha256_hash_engine_defines.svh"
module sha256_hash_engine import sha_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  sha_in_if.sink    in_i,
  sha_out_if.source out_o
);

  state_e            state_q, state_d;
  logic [5:0]        fill_q, fill_d;
  logic [63:0]       bits_q, bits_d;
  logic [WORD_W-1:0] hash_q [8];
  logic [WORD_W-1:0] hash_d [8];
  logic [WORD_W-1:0] v_q [8];
  logic [WORD_W-1:0] v_d [8];
  logic [WORD_W-1:0] win_q [BLK_WORDS];
  logic [WORD_W-1:0] win_d [BLK_WORDS];
  logic [5:0]        rnd_q, rnd_d;
  blk_cfg_t          cfg_q, cfg_d;
  logic              fin_q, fin_d;
  logic [2:0]        idx_q, idx_d;

  // Block buffer RAM
  logic [WORD_W-1:0] blk_mem [BLK_WORDS];
  logic [WORD_W-1:0] rd_data_q;
  logic [3:0]        rd_addr;
  logic              mem_we;

  logic              in_acc, out_acc;
  logic [6:0]        byte_pos;
  logic [WORD_W-1:0] fmt_word, w_t, t1, t2;

  assign in_acc  = in_i.valid && in_i.ready;
  assign out_acc = out_o.valid && out_o.ready;

  // Handshake and payload
  assign in_i.ready        = (state_q == ST_IDLE);
  assign out_o.valid       = (state_q == ST_OUT);
  assign out_o.digest_word = hash_q[idx_q];
  assign out_o.word_index  = idx_q;
  assign out_o.last_word   = (idx_q == 3'd7);

  // RAM: byte write at the fill position, registered word read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      blk_mem[fill_q[5:2]][{~fill_q[1:0], 3'b000} +: 8] <= in_i.data_byte;
    end
    rd_data_q <= blk_mem[rd_addr];
  end

  // Padding and length applied to the word read for this round
  always_comb begin
    fmt_word = '0;
    byte_pos = '0;
    for (int j = 0; j < 4; j++) begin
      byte_pos = {1'b0, rnd_q[3:0], 2'(j)};
      if (byte_pos < cfg_q.lim) begin
        fmt_word[(3-j)*8 +: 8] = rd_data_q[(3-j)*8 +: 8];
      end else if (byte_pos == cfg_q.lim && cfg_q.mark) begin
        fmt_word[(3-j)*8 +: 8] = 8'h80;
      end
    end
    if (cfg_q.len && rnd_q[3:0] == 4'd14) begin
      fmt_word = bits_q[63:32];
    end else if (cfg_q.len && rnd_q[3:0] == 4'd15) begin
      fmt_word = bits_q[31:0];
    end
  end

  // Schedule word and round sums
  always_comb begin
    if (rnd_q[5:4] == 2'd0) begin
      w_t = fmt_word;
    end else begin
      w_t = small_sigma1(win_q[14]) + win_q[9] + small_sigma0(win_q[1]) + win_q[0];
    end
    t1 = v_q[7] + big_sigma1(v_q[4]) + choose(v_q[4], v_q[5], v_q[6]) + K_TAB[rnd_q] + w_t;
    t2 = big_sigma0(v_q[0]) + majority(v_q[0], v_q[1], v_q[2]);
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && (in_i.command == CMD_FINISH || fill_q == 6'd63)) begin
          state_d = ST_START;
        end
      end
      ST_START: state_d = ST_ROUND;
      ST_ROUND: begin
        if (rnd_q == 6'd63) begin
          state_d = ST_FINAL;
        end
      end
      ST_FINAL: begin
        if (cfg_q.second) begin
          state_d = ST_START;
        end else if (fin_q) begin
          state_d = ST_OUT;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_OUT: begin
        if (out_acc && idx_q == 3'd7) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath control
  always_comb begin
    fill_d  = fill_q;
    bits_d  = bits_q;
    hash_d  = hash_q;
    v_d     = v_q;
    win_d   = win_q;
    rnd_d   = rnd_q;
    cfg_d   = cfg_q;
    fin_d   = fin_q;
    idx_d   = idx_q;
    rd_addr = '0;
    mem_we  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && in_i.command == CMD_ABSORB) begin
          mem_we = 1'b1;
          if (fill_q == 6'd63) begin
            fill_d = '0;
            bits_d = bits_q + 64'd512;
            cfg_d  = '{lim: 7'd64, mark: 1'b0, len: 1'b0, second: 1'b0};
            fin_d  = 1'b0;
          end else begin
            fill_d = fill_q + 6'd1;
          end
        end else if (in_acc) begin
          // Finish: count pending bytes, pick one or two padded blocks
          fill_d = '0;
          bits_d = bits_q + {55'd0, fill_q, 3'b000};
          fin_d  = 1'b1;
          if (fill_q >= 6'd56) begin
            cfg_d = '{lim: {1'b0, fill_q}, mark: 1'b1, len: 1'b0, second: 1'b1};
          end else begin
            cfg_d = '{lim: {1'b0, fill_q}, mark: 1'b1, len: 1'b1, second: 1'b0};
          end
        end
      end
      ST_START: begin
        v_d     = hash_q;
        rnd_d   = '0;
        rd_addr = '0;
      end
      ST_ROUND: begin
        rd_addr = rnd_q[3:0] + 4'd1;
        for (int i = 0; i < BLK_WORDS - 1; i++) begin
          win_d[i] = win_q[i+1];
        end
        win_d[BLK_WORDS-1] = w_t;
        v_d[7] = v_q[6];
        v_d[6] = v_q[5];
        v_d[5] = v_q[4];
        v_d[4] = v_q[3] + t1;
        v_d[3] = v_q[2];
        v_d[2] = v_q[1];
        v_d[1] = v_q[0];
        v_d[0] = t1 + t2;
        rnd_d  = rnd_q + 6'd1;
      end
      ST_FINAL: begin
        for (int i = 0; i < 8; i++) begin
          hash_d[i] = hash_q[i] + v_q[i];
        end
        if (cfg_q.second) begin
          cfg_d = '{lim: 7'd0, mark: 1'b0, len: 1'b1, second: 1'b0};
        end
        idx_d = '0;
      end
      ST_OUT: begin
        if (out_acc) begin
          idx_d = idx_q + 3'd1;
          if (idx_q == 3'd7) begin
            hash_d = H_INIT;
            bits_d = '0;
            fin_d  = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  // Control and hash state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fill_q  <= '0;
      bits_q  <= '0;
      hash_q  <= H_INIT;
      rnd_q   <= '0;
      cfg_q   <= '0;
      fin_q   <= 1'b0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      bits_q  <= bits_d;
      hash_q  <= hash_d;
      rnd_q   <= rnd_d;
      cfg_q   <= cfg_d;
      fin_q   <= fin_d;
      idx_q   <= idx_d;
    end
  end

  // Working variables and schedule window
  always_ff @(posedge clk_i) begin
    v_q   <= v_d;
    win_q <= win_d;
  end

  // Assertions
  `SHA_ASSERT_ALWAYS(a_no_in_while_out, !(in_i.ready && out_o.valid), "input ready while digest shown")
  `SHA_ASSERT(a_block_full_starts, (in_acc && in_i.command == CMD_ABSORB && fill_q == 6'd63) |=> (state_q == ST_START && fill_q == 6'd0), "full block did not start compression")
  `SHA_ASSERT(a_rounds_end, (state_q == ST_ROUND && rnd_q == 6'd63) |=> (state_q == ST_FINAL), "round count overran")
  `SHA_ASSERT(a_digest_done, (out_acc && out_o.last_word) |=> (in_i.ready && fill_q == 6'd0 && bits_q == 64'd0), "engine not reset after digest")

endmodule
